// File: src/dsch_pkg.sv
// Disk request scheduler package: sizes, codes, sequencer states and scan types.
// Used by dsch_scan and disk_request_scheduler; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dsch_pkg;

    localparam int CYLINDERS   = 256;
    localparam int CYL_W       = $clog2(CYLINDERS);
    localparam int CHUNK_W     = 32;
    localparam int CHUNK_BITS  = $clog2(CHUNK_W);
    localparam int NUM_CHUNKS  = CYLINDERS / CHUNK_W;
    localparam int CHUNK_IDX_W = $clog2(NUM_CHUNKS);

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_SET_HEAD = 2'd1,
        OP_SERVE    = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        POL_SCAN  = 2'd0,
        POL_CSCAN = 2'd1,
        POL_LOOK  = 2'd2,
        POL_SSTF  = 2'd3
    } t_policy;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_PASS_A = 2'd1,
        ST_PASS_B = 2'd2,
        ST_RESP   = 2'd3
    } t_state;

    typedef struct packed {
        logic                  hit;
        logic [CHUNK_BITS-1:0] idx;
    } t_scan_res;

endpackage
`default_nettype wire

// File: src/disk_request_scheduler.sv
// Disk request scheduler top level: pending bitmap, head, sweep state, sequencer.
// Depends on dsch_pkg and dsch_scan.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries i_opcode and i_cylinder.
//   Output channel (o_out_valid / i_out_ready) returns one result per input
//   transfer: o_served_cylinder and o_found.
//   Config channel (i_cfg_valid / o_cfg_ready) writes the policy register;
//   always ready, write only while idle.
//   Add and set-head: result valid the cycle after the input transfer.
//   Serve: the bitmap is scanned 32 cylinders per cycle by one shared
//   priority encoder, in at most two passes of up to 8 chunks each.
//   SSTF and the reversing or wrapping cases take the second pass.
//   One item in flight: o_in_ready is high only when idle and no result
//   waits; a stalled output holds its result until i_out_ready.
//   Reset clears the bitmap, head, sweep direction and policy (SCAN).
`timescale 1ns / 1ps
`default_nettype none
module disk_request_scheduler (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [1:0]                 i_cfg_policy_mode,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [1:0]                 i_opcode,
    input  wire logic [dsch_pkg::CYL_W-1:0] i_cylinder,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [dsch_pkg::CYL_W-1:0]      o_served_cylinder,
    output logic                            o_found
);

    localparam logic [dsch_pkg::CHUNK_IDX_W-1:0] LAST_CHUNK =
        dsch_pkg::CHUNK_IDX_W'(dsch_pkg::NUM_CHUNKS - 1);

    dsch_pkg::t_state                    r_state, n_state;
    dsch_pkg::t_policy                   r_policy;
    logic [dsch_pkg::CYLINDERS-1:0]      r_pending, n_pending;
    logic [dsch_pkg::CYL_W-1:0]          r_head, n_head;
    logic                                r_sweep_down, n_sweep_down;
    logic [dsch_pkg::CHUNK_IDX_W-1:0]    r_chunk, n_chunk;
    logic                                r_dir_down, n_dir_down;
    logic [dsch_pkg::CYL_W-1:0]          r_bound, n_bound;
    logic [dsch_pkg::CYL_W-1:0]          r_up_pick, n_up_pick;
    logic                                r_up_found, n_up_found;
    logic [dsch_pkg::CYL_W-1:0]          r_out_cyl, n_out_cyl;
    logic                                r_out_found, n_out_found;

    logic                                w_in_xfer;
    logic                                w_last;
    logic [dsch_pkg::CYL_W-1:0]          w_pick;
    logic [dsch_pkg::CYL_W-1:0]          w_up_dist;
    logic [dsch_pkg::CYL_W-1:0]          w_dn_dist;
    logic [dsch_pkg::CHUNK_W-1:0]        w_word;
    dsch_pkg::t_scan_res                 w_res;

    assign w_in_xfer = i_in_valid && o_in_ready;
    assign w_word    = r_pending[{r_chunk, dsch_pkg::CHUNK_BITS'(0)} +: dsch_pkg::CHUNK_W];
    assign w_pick    = {r_chunk, w_res.idx};
    assign w_last    = r_dir_down ? (r_chunk == '0) : (r_chunk == LAST_CHUNK);
    assign w_up_dist = r_up_pick - r_head;
    assign w_dn_dist = r_head - w_pick;

    dsch_scan u_scan (
        .i_word     (w_word),
        .i_dir_down (r_dir_down),
        .i_mask_en  (r_chunk == r_bound[dsch_pkg::CYL_W-1 -: dsch_pkg::CHUNK_IDX_W]),
        .i_bound    (r_bound[dsch_pkg::CHUNK_BITS-1:0]),
        .o_res      (w_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dsch_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = (dsch_pkg::t_opcode'(i_opcode) == dsch_pkg::OP_SERVE) ?
                              dsch_pkg::ST_PASS_A : dsch_pkg::ST_RESP;
                end
            end
            dsch_pkg::ST_PASS_A: begin
                if (w_res.hit && r_policy != dsch_pkg::POL_SSTF) begin
                    n_state = dsch_pkg::ST_RESP;
                end else if (w_res.hit || w_last) begin
                    n_state = dsch_pkg::ST_PASS_B;
                end
            end
            dsch_pkg::ST_PASS_B: begin
                if (w_res.hit || w_last) begin
                    n_state = dsch_pkg::ST_RESP;
                end
            end
            dsch_pkg::ST_RESP: begin
                if (i_out_ready) begin
                    n_state = dsch_pkg::ST_IDLE;
                end
            end
            default: n_state = dsch_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_pending    = r_pending;
        n_head       = r_head;
        n_sweep_down = r_sweep_down;
        n_chunk      = r_chunk;
        n_dir_down   = r_dir_down;
        n_bound      = r_bound;
        n_up_pick    = r_up_pick;
        n_up_found   = r_up_found;
        n_out_cyl    = r_out_cyl;
        n_out_found  = r_out_found;
        case (r_state)
            dsch_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    n_out_cyl   = '0;
                    n_out_found = 1'b0;
                    case (dsch_pkg::t_opcode'(i_opcode))
                        dsch_pkg::OP_ADD: begin
                            n_pending[i_cylinder] = 1'b1;
                        end
                        dsch_pkg::OP_SET_HEAD: begin
                            n_head       = i_cylinder;
                            n_sweep_down = 1'b0;
                        end
                        dsch_pkg::OP_SERVE: begin
                            n_bound    = r_head;
                            n_chunk    = r_head[dsch_pkg::CYL_W-1 -: dsch_pkg::CHUNK_IDX_W];
                            n_dir_down = (r_policy == dsch_pkg::POL_SCAN ||
                                          r_policy == dsch_pkg::POL_LOOK) ?
                                         r_sweep_down : 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            dsch_pkg::ST_PASS_A: begin
                if (w_res.hit && r_policy != dsch_pkg::POL_SSTF) begin
                    n_pending[w_pick] = 1'b0;
                    n_head            = w_pick;
                    n_out_cyl         = w_pick;
                    n_out_found       = 1'b1;
                end else if (w_res.hit || w_last) begin
                    n_up_pick  = w_pick;
                    n_up_found = w_res.hit;
                    n_bound    = r_head;
                    n_chunk    = r_head[dsch_pkg::CYL_W-1 -: dsch_pkg::CHUNK_IDX_W];
                    n_dir_down = !r_dir_down;
                    if (r_policy == dsch_pkg::POL_SSTF) begin
                        n_dir_down = 1'b1;
                    end else if (r_policy == dsch_pkg::POL_CSCAN) begin
                        n_bound    = '0;
                        n_chunk    = '0;
                        n_dir_down = 1'b0;
                    end
                end else begin
                    n_chunk = r_dir_down ? r_chunk - dsch_pkg::CHUNK_IDX_W'(1) :
                                           r_chunk + dsch_pkg::CHUNK_IDX_W'(1);
                end
            end
            dsch_pkg::ST_PASS_B: begin
                if (w_res.hit || w_last) begin
                    n_out_cyl   = '0;
                    n_out_found = 1'b0;
                    if (r_policy == dsch_pkg::POL_SSTF) begin
                        if (r_up_found && (!w_res.hit || w_up_dist <= w_dn_dist)) begin
                            n_out_cyl   = r_up_pick;
                            n_out_found = 1'b1;
                        end else if (w_res.hit) begin
                            n_out_cyl   = w_pick;
                            n_out_found = 1'b1;
                        end
                    end else if (w_res.hit) begin
                        n_out_cyl   = w_pick;
                        n_out_found = 1'b1;
                        if (r_policy != dsch_pkg::POL_CSCAN) begin
                            n_sweep_down = r_dir_down;
                        end
                    end
                    if (n_out_found) begin
                        n_pending[n_out_cyl] = 1'b0;
                        n_head               = n_out_cyl;
                    end
                end else begin
                    n_chunk = r_dir_down ? r_chunk - dsch_pkg::CHUNK_IDX_W'(1) :
                                           r_chunk + dsch_pkg::CHUNK_IDX_W'(1);
                end
            end
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        o_cfg_ready       = 1'b1;
        o_in_ready        = (r_state == dsch_pkg::ST_IDLE);
        o_out_valid       = (r_state == dsch_pkg::ST_RESP);
        o_served_cylinder = r_out_cyl;
        o_found           = r_out_found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= dsch_pkg::ST_IDLE;
            r_policy     <= dsch_pkg::POL_SCAN;
            r_pending    <= '0;
            r_head       <= '0;
            r_sweep_down <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pending    <= n_pending;
            r_head       <= n_head;
            r_sweep_down <= n_sweep_down;
            if (i_cfg_valid && o_cfg_ready) begin
                r_policy <= dsch_pkg::t_policy'(i_cfg_policy_mode);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chunk     <= n_chunk;
        r_dir_down  <= n_dir_down;
        r_bound     <= n_bound;
        r_up_pick   <= n_up_pick;
        r_up_found  <= n_up_found;
        r_out_cyl   <= n_out_cyl;
        r_out_found <= n_out_found;
    end

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    a_head_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (r_head == o_served_cylinder))
        else $error("head not moved to served cylinder");

    a_served_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> !r_pending[o_served_cylinder])
        else $error("served request still pending");

    a_non_serve_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && dsch_pkg::t_opcode'(i_opcode) != dsch_pkg::OP_SERVE) |=>
        (o_out_valid && !o_found && o_served_cylinder == '0))
        else $error("non-serve transfer gave a nonzero or late result");

endmodule
`default_nettype wire

// File: src/dsch_scan.sv
// Chunk scanner: nearest set bit of one bitmap chunk, up or down from a bound.
// Depends on dsch_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dsch_scan (
    input  wire logic [dsch_pkg::CHUNK_W-1:0]    i_word,
    input  wire logic                            i_dir_down,
    input  wire logic                            i_mask_en,
    input  wire logic [dsch_pkg::CHUNK_BITS-1:0] i_bound,
    output dsch_pkg::t_scan_res                  o_res
);

    logic [dsch_pkg::CHUNK_W-1:0] w_masked;

    always_comb begin
        for (int k = 0; k < dsch_pkg::CHUNK_W; k++) begin
            if (i_dir_down) begin
                w_masked[k] = i_word[k] &
                    (!i_mask_en || (dsch_pkg::CHUNK_BITS'(k) <= i_bound));
            end else begin
                w_masked[k] = i_word[k] &
                    (!i_mask_en || (dsch_pkg::CHUNK_BITS'(k) >= i_bound));
            end
        end
    end

    // up: lowest set bit; down: highest set bit
    always_comb begin
        o_res.hit = |w_masked;
        o_res.idx = '0;
        if (i_dir_down) begin
            for (int k = 0; k < dsch_pkg::CHUNK_W; k++) begin
                if (w_masked[k]) begin
                    o_res.idx = dsch_pkg::CHUNK_BITS'(k);
                end
            end
        end else begin
            for (int k = dsch_pkg::CHUNK_W - 1; k >= 0; k--) begin
                if (w_masked[k]) begin
                    o_res.idx = dsch_pkg::CHUNK_BITS'(k);
                end
            end
        end
    end

endmodule
`default_nettype wire
